### sv/hlfr_pkg.sv
// package for the header/length framed serial receiver
// holds field widths, register indexes, reset values and shared structs
`default_nettype none

package hlfr_pkg;

  localparam int unsigned DataW     = 8;
  localparam int unsigned IdxW      = 5;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned LenW      = 8;
  localparam int unsigned CountLimitDef = 30;

  localparam logic [CfgIdxW-1:0] RegHeaderFirst    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHeaderSecond   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegStopCommand    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegStopAddressHigh = 3'd3;
  localparam logic [CfgIdxW-1:0] RegStopAddressLow = 3'd4;

  localparam logic [DataW-1:0] HeaderFirstRst     = 8'h5a;
  localparam logic [DataW-1:0] HeaderSecondRst    = 8'ha5;
  localparam logic [DataW-1:0] StopCommandRst     = 8'h83;
  localparam logic [DataW-1:0] StopAddressHighRst = 8'h60;
  localparam logic [DataW-1:0] StopAddressLowRst  = 8'h00;

  typedef struct packed {
    logic [DataW-1:0] header_first;
    logic [DataW-1:0] header_second;
    logic [DataW-1:0] stop_command;
    logic [DataW-1:0] stop_address_high;
    logic [DataW-1:0] stop_address_low;
  } cfg_t;

  typedef struct packed {
    logic            done;
    logic            stop;
    logic [LenW-1:0] len;
  } frame_info_t;

endpackage

`default_nettype wire

### sv/hlfr_stream_if.sv
// stream interfaces for the received byte channel and the frame byte channel
// depends on hlfr_pkg for field widths
`default_nettype none

interface hlfr_rx_if;
  logic                        valid;
  logic                        ready;
  logic [hlfr_pkg::DataW-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hlfr_frame_if;
  logic                        valid;
  logic                        ready;
  logic [hlfr_pkg::DataW-1:0]  frame_byte;
  logic [hlfr_pkg::IdxW-1:0]   byte_index;
  logic [hlfr_pkg::IdxW-1:0]   frame_length;
  logic                        is_stop;
  logic                        last;

  modport source (output valid, output frame_byte, output byte_index, output frame_length,
                  output is_stop, output last, input ready);
  modport sink   (input valid, input frame_byte, input byte_index, input frame_length,
                  input is_stop, input last, output ready);
endinterface

`default_nettype wire

### sv/header_length_frame_receiver.sv
// top level of the header/length framed serial receiver: config registers,
// frame buffer memory and frame readout; depends on hlfr_pkg, hlfr_stream_if, hlfr_parse
//
//   channel  dir  handshake        payload
//   rx       in   valid/ready      rx_byte
//   frame    out  valid/ready      frame_byte, byte_index, frame_length, is_stop, last
//   cfg      in   cfg_we_i         cfg_index_i, cfg_wdata_i
//
// an rx transaction takes one cycle while no frame is being read out
// a completed frame is read from the buffer one byte a cycle while frame does not
// stall, and rx is held off from the completing byte until its last byte is read
// the last frame byte may wait in the output register while rx runs again
// reset clears the byte count, readout control and config registers
`default_nettype none

module header_length_frame_receiver #(
  parameter int unsigned CountLimit = hlfr_pkg::CountLimitDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  hlfr_rx_if.sink                            rx,
  hlfr_frame_if.source                       frame,
  input  wire logic                          cfg_we_i,
  input  wire logic [hlfr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [hlfr_pkg::DataW-1:0]    cfg_wdata_i
);

  localparam int unsigned CntW  = $clog2(CountLimit + 2);
  localparam int unsigned AddrW = $clog2(CountLimit + 1);
  localparam int unsigned Depth = CountLimit + 1;

  hlfr_pkg::cfg_t         cfg_q;
  hlfr_pkg::frame_info_t  info;
  logic [AddrW-1:0]       wr_addr;
  logic                   rx_accept;

  logic [hlfr_pkg::DataW-1:0] mem [Depth];

  logic                        emit_q;
  logic [CntW-1:0]             rd_k_q;
  logic [CntW-1:0]             rd_k_inc;
  logic [CntW-1:0]             len_q;
  logic                        stop_q;
  logic                        rd_en;
  logic                        rd_last;

  logic                        out_valid_q;
  logic [hlfr_pkg::DataW-1:0]  rd_data_q;
  logic [hlfr_pkg::IdxW-1:0]   out_idx_q, out_len_q;
  logic                        out_stop_q, out_last_q;

  assign rx.ready  = !emit_q;
  assign rx_accept = rx.valid && rx.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_first      <= hlfr_pkg::HeaderFirstRst;
      cfg_q.header_second     <= hlfr_pkg::HeaderSecondRst;
      cfg_q.stop_command      <= hlfr_pkg::StopCommandRst;
      cfg_q.stop_address_high <= hlfr_pkg::StopAddressHighRst;
      cfg_q.stop_address_low  <= hlfr_pkg::StopAddressLowRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        hlfr_pkg::RegHeaderFirst:     cfg_q.header_first      <= cfg_wdata_i;
        hlfr_pkg::RegHeaderSecond:    cfg_q.header_second     <= cfg_wdata_i;
        hlfr_pkg::RegStopCommand:     cfg_q.stop_command      <= cfg_wdata_i;
        hlfr_pkg::RegStopAddressHigh: cfg_q.stop_address_high <= cfg_wdata_i;
        hlfr_pkg::RegStopAddressLow:  cfg_q.stop_address_low  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  hlfr_parse #(
    .CountLimit (CountLimit)
  ) u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (rx_accept),
    .byte_i    (rx.rx_byte),
    .cfg_i     (cfg_q),
    .wr_addr_o (wr_addr),
    .info_o    (info)
  );

  // one write port for received bytes, one registered read port for readout
  assign rd_en    = emit_q && (!out_valid_q || frame.ready);
  assign rd_k_inc = rd_k_q + CntW'(1);
  assign rd_last  = (rd_k_inc == len_q);

  always_ff @(posedge clk_i) begin
    if (rx_accept) begin
      mem[wr_addr] <= rx.rx_byte;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_k_q[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q      <= 1'b0;
      rd_k_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (info.done) begin
        emit_q <= 1'b1;
        rd_k_q <= '0;
      end else if (rd_en) begin
        rd_k_q <= rd_k_inc;
        if (rd_last) emit_q <= 1'b0;
      end
      if (rd_en) begin
        out_valid_q <= 1'b1;
      end else if (frame.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (info.done) begin
      len_q  <= info.len[CntW-1:0];
      stop_q <= info.stop;
    end
    if (rd_en) begin
      out_idx_q  <= hlfr_pkg::IdxW'(rd_k_q);
      out_len_q  <= hlfr_pkg::IdxW'(len_q);
      out_stop_q <= stop_q;
      out_last_q <= rd_last;
    end
  end

  assign frame.valid        = out_valid_q;
  assign frame.frame_byte   = rd_data_q;
  assign frame.byte_index   = out_idx_q;
  assign frame.frame_length = out_len_q;
  assign frame.is_stop      = out_stop_q;
  assign frame.last         = out_last_q;

endmodule

`default_nettype wire

### sv/hlfr_parse.sv
// frame parser: byte count, header check, length and stop match
// depends on hlfr_pkg; drives the frame buffer write address
`default_nettype none

module hlfr_parse #(
  parameter int unsigned CountLimit = hlfr_pkg::CountLimitDef,
  localparam int unsigned CntW = $clog2(CountLimit + 2),
  localparam int unsigned AddrW = $clog2(CountLimit + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire logic [hlfr_pkg::DataW-1:0]  byte_i,
  input  wire hlfr_pkg::cfg_t              cfg_i,
  output logic [AddrW-1:0]                 wr_addr_o,
  output hlfr_pkg::frame_info_t            info_o
);

  logic [CntW-1:0]             count_q, count_d;
  logic [CntW-1:0]             count_inc;
  logic [hlfr_pkg::DataW-1:0]  b0_q, len_byte_q, b3_q, b4_q, b5_q;
  logic [hlfr_pkg::DataW-1:0]  len_field, byte5;
  logic [hlfr_pkg::LenW-1:0]   count_ext;
  logic                        done;

  assign count_inc = count_q + CntW'(1);
  assign count_ext = hlfr_pkg::LenW'(count_inc);
  assign wr_addr_o = count_q[AddrW-1:0];
  assign len_field = (count_q == CntW'(2)) ? byte_i : len_byte_q;
  assign byte5     = (count_q == CntW'(5)) ? byte_i : b5_q;

  always_comb begin
    done    = 1'b0;
    count_d = count_q;
    if (count_q == '0) begin
      count_d = (byte_i == cfg_i.header_first) ? count_inc : '0;
    end else if (count_q == CntW'(1)) begin
      count_d = ((byte_i == cfg_i.header_second) && (b0_q == cfg_i.header_first)) ?
                count_inc : '0;
    end else if ((count_ext - hlfr_pkg::LenW'(3)) == len_field) begin
      done    = 1'b1;
      count_d = '0;
    end else if (count_inc > CntW'(CountLimit)) begin
      count_d = '0;
    end else begin
      count_d = count_inc;
    end
  end

  assign info_o.done = accept_i && done;
  assign info_o.len  = count_ext;
  assign info_o.stop = (count_inc >= CntW'(6)) &&
                       (b3_q == cfg_i.stop_command) &&
                       (b4_q == cfg_i.stop_address_high) &&
                       (byte5 == cfg_i.stop_address_low);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept_i) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      if (count_q == '0) b0_q <= byte_i;
      if (count_q == CntW'(2)) len_byte_q <= byte_i;
      if (count_q == CntW'(3)) b3_q <= byte_i;
      if (count_q == CntW'(4)) b4_q <= byte_i;
      if (count_q == CntW'(5)) b5_q <= byte_i;
    end
  end

endmodule

`default_nettype wire

### sim/tb_top.sv
// testbench for header_length_frame_receiver: random and directed byte streams
// checked against an in-bench frame predictor; depends on hlfr_pkg, hlfr_stream_if
`timescale 1ns / 1ps

module tb_top;
  import hlfr_pkg::*;

  localparam int CountLimit    = 30;
  localparam int StoreDepth    = CountLimit + 1;
  localparam int MaxLenByte    = CountLimit - 2;
  localparam int ShortestStop  = 6;
  localparam int DrainCycles   = 64;
  localparam int WatchdogLimit = 2000;
  localparam int ItemsPerPhase = 16;

  localparam logic [CfgIdxW-1:0] RegUnusedLo = 3'd5;
  localparam logic [CfgIdxW-1:0] RegUnusedHi = 3'd7;

  typedef struct packed {
    logic [DataW-1:0] frame_byte;
    logic [IdxW-1:0]  byte_index;
    logic [IdxW-1:0]  frame_length;
    logic             is_stop;
    logic             last;
  } frame_beat_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [DataW-1:0]   cfg_wdata;

  hlfr_rx_if    rx_if ();
  hlfr_frame_if frame_if ();

  logic [DataW-1:0] pending_bytes [$];
  frame_beat_t      expected_beats [$];

  cfg_t             shadow_cfg;
  cfg_t             plan_cfg;
  logic [DataW-1:0] shadow_store [StoreDepth];
  int               shadow_count;

  int  mismatch_count;
  int  queued_items;
  int  idle_cycles;
  int  send_gap;
  int  stall_left;
  bit  idle_en;

  header_length_frame_receiver #(
    .CountLimit(CountLimit)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .rx         (rx_if),
    .frame      (frame_if),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 60);
  endfunction

  function automatic void deframe_byte(input logic [DataW-1:0] b);
    int          frame_len;
    logic        stop_hit;
    frame_beat_t beat;
    if (shadow_count >= StoreDepth) shadow_count = 0;
    shadow_store[shadow_count] = b;
    shadow_count++;
    if (shadow_count == 1) begin
      if (shadow_store[0] != shadow_cfg.header_first) shadow_count = 0;
    end else if (shadow_count == 2) begin
      if (shadow_store[0] != shadow_cfg.header_first ||
          shadow_store[1] != shadow_cfg.header_second) shadow_count = 0;
    end else if (shadow_count - 3 == int'(shadow_store[2])) begin
      frame_len = shadow_count;
      shadow_count = 0;
      stop_hit = (frame_len >= ShortestStop) &&
                 (shadow_store[3] == shadow_cfg.stop_command) &&
                 (shadow_store[4] == shadow_cfg.stop_address_high) &&
                 (shadow_store[5] == shadow_cfg.stop_address_low);
      for (int k = 0; k < frame_len; k++) begin
        beat.frame_byte   = shadow_store[k];
        beat.byte_index   = IdxW'(k);
        beat.frame_length = IdxW'(frame_len);
        beat.is_stop      = stop_hit;
        beat.last         = (k + 1 == frame_len);
        expected_beats.push_back(beat);
      end
    end
    if (shadow_count > CountLimit) shadow_count = 0;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // rx driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rx_if.valid   <= 1'b0;
      rx_if.rx_byte <= '0;
      send_gap = 0;
    end else if (!rx_if.valid || rx_if.ready) begin
      if (send_gap > 0) begin
        send_gap--;
        rx_if.valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= pending_bytes.pop_front();
        send_gap = (idle_en && $urandom_range(0, 99) < 35) ? draw_gap() : 0;
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  // config mirror, prediction and frame monitor
  always @(posedge clk or negedge rst_n) begin
    frame_beat_t want;
    if (!rst_n) begin
      frame_if.ready <= 1'b0;
      stall_left = 0;
      shadow_count = 0;
      shadow_cfg = '{HeaderFirstRst, HeaderSecondRst, StopCommandRst,
                     StopAddressHighRst, StopAddressLowRst};
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegHeaderFirst:     shadow_cfg.header_first      = cfg_wdata;
          RegHeaderSecond:    shadow_cfg.header_second     = cfg_wdata;
          RegStopCommand:     shadow_cfg.stop_command      = cfg_wdata;
          RegStopAddressHigh: shadow_cfg.stop_address_high = cfg_wdata;
          RegStopAddressLow:  shadow_cfg.stop_address_low  = cfg_wdata;
          default: ;
        endcase
      end
      if (rx_if.valid && rx_if.ready) deframe_byte(rx_if.rx_byte);
      if (frame_if.valid && frame_if.ready) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected frame transaction, expected none, got byte %0d index %0d",
                   $time, frame_if.frame_byte, frame_if.byte_index);
          mismatch_count++;
        end else begin
          want = expected_beats.pop_front();
          check_field("frame_byte", want.frame_byte, frame_if.frame_byte);
          check_field("byte_index", want.byte_index, frame_if.byte_index);
          check_field("frame_length", want.frame_length, frame_if.frame_length);
          check_field("is_stop", want.is_stop, frame_if.is_stop);
          check_field("last", want.last, frame_if.last);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        frame_if.ready <= 1'b0;
      end else begin
        frame_if.ready <= 1'b1;
        if (idle_en && $urandom_range(0, 99) < 20) stall_left = draw_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (rx_if.valid && rx_if.ready) ||
        (frame_if.valid && frame_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("header_length_frame_receiver test failed");
        $finish;
      end
    end
  end

  task automatic queue_rx(input logic [DataW-1:0] b);
    pending_bytes.push_back(b);
    queued_items++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_config(input cfg_t c);
    write_reg(RegHeaderFirst, c.header_first);
    write_reg(RegHeaderSecond, c.header_second);
    write_reg(RegStopCommand, c.stop_command);
    write_reg(RegStopAddressHigh, c.stop_address_high);
    write_reg(RegStopAddressLow, c.stop_address_low);
    write_reg(CfgIdxW'($urandom_range(RegUnusedLo, RegUnusedHi)), DataW'($urandom));
    plan_cfg = c;
    @(posedge clk);
  endtask

  // len_byte above the limit sends just enough bytes to overflow the count
  task automatic add_frame(input int len_byte, input bit stop_like);
    int n;
    logic [DataW-1:0] stop_bytes [3];
    stop_bytes = '{plan_cfg.stop_command, plan_cfg.stop_address_high,
                   plan_cfg.stop_address_low};
    n = (len_byte > MaxLenByte) ? MaxLenByte : len_byte;
    queue_rx(plan_cfg.header_first);
    queue_rx(plan_cfg.header_second);
    queue_rx(DataW'(len_byte));
    for (int k = 0; k < n; k++) begin
      if (stop_like && k < 3) queue_rx(stop_bytes[k]);
      else queue_rx(DataW'($urandom));
    end
  endtask

  task automatic add_random(input int target);
    int r;
    int len_byte;
    int stop_start;
    stop_start = queued_items;
    while (queued_items - stop_start < target) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        len_byte = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 6)
                                              : $urandom_range(7, MaxLenByte);
        add_frame(len_byte, $urandom_range(0, 2) == 0);
      end else if (r < 80) begin
        queue_rx(plan_cfg.header_first);
        queue_rx(plan_cfg.header_second ^ DataW'($urandom_range(1, 255)));
      end else if (r < 88) begin
        repeat ($urandom_range(1, 3))
          queue_rx(plan_cfg.header_first ^ DataW'($urandom_range(1, 255)));
      end else if (r < 94) begin
        add_frame($urandom_range(MaxLenByte + 1, 255), 1'b0);
      end else begin
        len_byte = $urandom_range(3, 10);
        queue_rx(plan_cfg.header_first);
        queue_rx(plan_cfg.header_second);
        queue_rx(DataW'(len_byte));
        repeat ($urandom_range(0, len_byte - 1)) queue_rx(DataW'($urandom));
      end
    end
  endtask

  task automatic finish_phase();
    while (pending_bytes.size() != 0 || rx_if.valid || expected_beats.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin
    cfg_t c;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    rx_if.valid    = 1'b0;
    rx_if.rx_byte  = '0;
    frame_if.ready = 1'b0;
    idle_en        = 1'b1;
    mismatch_count = 0;
    queued_items   = 0;
    idle_cycles    = 0;
    plan_cfg = '{HeaderFirstRst, HeaderSecondRst, StopCommandRst,
                 StopAddressHighRst, StopAddressLowRst};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bad first header, then second header byte equal to the first header
    queue_rx(8'h00);
    queue_rx(plan_cfg.header_first);
    queue_rx(plan_cfg.header_first);
    add_frame(0, 1'b0);
    // short frame carrying stop bytes is not a stop frame
    queue_rx(plan_cfg.header_first);
    queue_rx(plan_cfg.header_second);
    queue_rx(8'd2);
    queue_rx(plan_cfg.stop_command);
    queue_rx(plan_cfg.stop_address_high);
    add_frame(3, 1'b1);
    queue_rx(plan_cfg.header_first);
    queue_rx(plan_cfg.header_second);
    queue_rx(8'd1);
    queue_rx(8'hff);
    finish_phase();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       c = '0;
        1:       c = '1;
        default: c = cfg_t'({$urandom, $urandom});
      endcase
      set_config(c);
      idle_en = (phase != 3);
      if (phase == 0) begin
        add_frame(MaxLenByte, 1'b1);
        add_frame(MaxLenByte + 1, 1'b0);
      end
      add_random(ItemsPerPhase);
      finish_phase();
    end

    if (mismatch_count == 0 && expected_beats.size() == 0) begin
      $display("header_length_frame_receiver test passed");
    end else begin
      $display("header_length_frame_receiver test failed");
    end
    $finish;
  end

endmodule
